@@ rtl/core/cbl_pkg.sv @@
// ----------------------------------------------------------------------------
// Cascaded Butterworth low-pass: shared package
// Types, fixed-point constants and rounding helpers used by the filter core.
// ----------------------------------------------------------------------------
`default_nettype none

package cbl_pkg;

	// Configuration register indexes.
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_FILTER_ORDER     = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SMOOTHING_FACTOR = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STAGE0_COEFS     = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STAGE1_COEFS     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_STAGE2_COEFS     = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_STAGE3_COEFS     = 3'd5;

	localparam int CFG_DATA_W  = 54;
	localparam int ORDER_W     = 4;
	localparam int ALPHA_W     = 16;
	localparam int STAGE_REGS  = 4;
	localparam int STAGE_IDX_W = 2;
	localparam int COEF_W      = 18;
	localparam int A1_LSB      = 18;
	localparam int A2_LSB      = 36;
	localparam logic [ORDER_W-1:0] ORDER_LIMIT = 4'd8;

	// Datapath word sizes.
	localparam int SAMPLE_W  = 16;
	localparam int STATE_W   = 24;
	localparam int STATE_FRAC = 8;
	localparam int TAP_SUM_W = 26;
	localparam int PROD_W    = TAP_SUM_W + COEF_W;
	localparam int ACC_W     = 48;
	localparam int PROD_FRAC = 16;
	localparam int STAGE_CNT_W = 3;

	localparam logic signed [ACC_W-1:0] ACC_ROUND   = ACC_W'(32768);
	localparam logic signed [ACC_W-1:0] ACC_SAT_MAX = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] ACC_SAT_MIN = ACC_W'(-8388608);

	localparam logic signed [STATE_W:0] OUT_ROUND   = (STATE_W+1)'(128);
	localparam logic signed [STATE_W:0] OUT_SAT_MAX = (STATE_W+1)'(32767);
	localparam logic signed [STATE_W:0] OUT_SAT_MIN = (STATE_W+1)'(-32768);

	typedef logic [CFG_DATA_W-1:0] coef_reg_t;

	// One row of biquad history per axis and stage.
	typedef struct packed {
		logic signed [STATE_W-1:0] x1;
		logic signed [STATE_W-1:0] x2;
		logic signed [STATE_W-1:0] y1;
		logic signed [STATE_W-1:0] y2;
	} row_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SM_MUL0,
		S_SM_MUL1,
		S_SM_ROUND,
		S_ST_SUM,
		S_ST_MUL0,
		S_ST_MUL1,
		S_ST_MUL2,
		S_ST_ROUND,
		S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SM_MUL0,
		OP_SM_MUL1,
		OP_SM_ROUND,
		OP_ST_SUM,
		OP_ST_MUL0,
		OP_ST_MUL1,
		OP_ST_MUL2,
		OP_ST_ROUND,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic [STAGE_IDX_W-1:0] stage;
		logic                   rd;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	// Round a Q.24 product sum to Q.8 and saturate to the state width.
	function automatic logic signed [STATE_W-1:0] round_sat_state(
		input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-1:0] sh;
		sh = (acc + ACC_ROUND) >>> PROD_FRAC;
		if (sh > ACC_SAT_MAX)
			return STATE_W'(ACC_SAT_MAX);
		else if (sh < ACC_SAT_MIN)
			return STATE_W'(ACC_SAT_MIN);
		else
			return sh[STATE_W-1:0];
	endfunction

	// Round a Q15.8 value to an integer sample and saturate to 16 bits.
	function automatic logic signed [SAMPLE_W-1:0] round_sat_sample(
		input logic signed [STATE_W-1:0] v);
		logic signed [STATE_W:0] t;
		t = ((STATE_W+1)'(v) + OUT_ROUND) >>> STATE_FRAC;
		if (t > OUT_SAT_MAX)
			return SAMPLE_W'(OUT_SAT_MAX);
		else if (t < OUT_SAT_MIN)
			return SAMPLE_W'(OUT_SAT_MIN);
		else
			return t[SAMPLE_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/cascaded_butterworth_lowpass.sv @@
// ----------------------------------------------------------------------------
// Cascaded Butterworth low-pass filter
// Usage:
// Samples enter on the sample channel (sample_valid, sample_stall) with an
// axis tag; each item gives one result on the result channel (result_valid,
// result_stall). Coefficients and the order are written through the cfg
// channel, which is always ready; a write to a listed register also clears
// the history of all axes.
// Each accepted item runs the load step, the smoother (two products and a
// rounding) for an odd order, then per biquad stage a tap sum, three products
// and a rounding, and the output step. Bypassed items (order zero or an axis
// beyond the configured count) go straight from load to output. A new item is
// accepted only once the last one has left its final step, and the single
// shared multiply-accumulate unit computes one product per cycle.
// The result register lets a new item be accepted while a result waits; if
// the receiver stalls, the next item holds in its final step until the
// register is free. Reset clears the configuration and control registers and
// all filter history.
`default_nettype none

module cascaded_butterworth_lowpass #(
	parameter int AXIS_COUNT = 3,
	parameter int MAX_STAGES = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                sample_valid,
	output logic                                     sample_stall,
	input  wire logic [1:0]                          axis_index,
	input  wire logic signed [cbl_pkg::SAMPLE_W-1:0] raw_sample,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output logic signed [cbl_pkg::SAMPLE_W-1:0]      filtered_sample,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cbl_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire logic [cbl_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic [cbl_pkg::ORDER_W-1:0] filter_order_q;
	logic [cbl_pkg::ALPHA_W-1:0] smoothing_factor_q;
	cbl_pkg::coef_reg_t          stage_coef_q [cbl_pkg::STAGE_REGS];

	logic           cfg_write;
	logic           clear_state;
	cbl_pkg::cmd_t  cmd;
	cbl_pkg::stat_t stat;

	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	always_comb begin
		unique case (cfg_index) inside
			cbl_pkg::REG_FILTER_ORDER, cbl_pkg::REG_SMOOTHING_FACTOR,
			cbl_pkg::REG_STAGE0_COEFS, cbl_pkg::REG_STAGE1_COEFS,
			cbl_pkg::REG_STAGE2_COEFS, cbl_pkg::REG_STAGE3_COEFS:
				clear_state = cfg_write;
			default:
				clear_state = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_order_q     <= '0;
			smoothing_factor_q <= '0;
			for (int i = 0; i < cbl_pkg::STAGE_REGS; i++)
				stage_coef_q[i] <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cbl_pkg::REG_FILTER_ORDER:
					filter_order_q <= cfg_data[cbl_pkg::ORDER_W-1:0];
				cbl_pkg::REG_SMOOTHING_FACTOR:
					smoothing_factor_q <= cfg_data[cbl_pkg::ALPHA_W-1:0];
				cbl_pkg::REG_STAGE0_COEFS:
					stage_coef_q[0] <= cfg_data;
				cbl_pkg::REG_STAGE1_COEFS:
					stage_coef_q[1] <= cfg_data;
				cbl_pkg::REG_STAGE2_COEFS:
					stage_coef_q[2] <= cfg_data;
				cbl_pkg::REG_STAGE3_COEFS:
					stage_coef_q[3] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cbl_ctrl #(
		.AXIS_COUNT(AXIS_COUNT),
		.MAX_STAGES(MAX_STAGES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.axis_index  (axis_index),
		.filter_order(filter_order_q),
		.stat        (stat),
		.cmd         (cmd)
	);

	cbl_datapath #(
		.AXIS_COUNT(AXIS_COUNT),
		.MAX_STAGES(MAX_STAGES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.clear          (clear_state),
		.cmd            (cmd),
		.stat           (stat),
		.axis_index     (axis_index),
		.raw_sample     (raw_sample),
		.alpha          (smoothing_factor_q),
		.stage_coefs    (stage_coef_q),
		.result_stall   (result_stall),
		.result_valid   (result_valid),
		.filtered_sample(filtered_sample)
	);

endmodule

`default_nettype wire

@@ rtl/core/cbl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbl_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 12
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/cbl_datapath.sv @@
// ----------------------------------------------------------------------------
// Cascaded Butterworth low-pass: datapath
// Shared multiply-accumulate unit, per-axis smoother memory, biquad history
// RAM with valid bits, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbl_datapath #(
	parameter int AXIS_COUNT = 3,
	parameter int MAX_STAGES = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  clear,
	input  wire cbl_pkg::cmd_t                         cmd,
	output cbl_pkg::stat_t                             stat,
	input  wire logic [1:0]                            axis_index,
	input  wire logic signed [cbl_pkg::SAMPLE_W-1:0]   raw_sample,
	input  wire logic [cbl_pkg::ALPHA_W-1:0]           alpha,
	input  wire cbl_pkg::coef_reg_t                    stage_coefs [cbl_pkg::STAGE_REGS],
	input  wire logic                                  result_stall,
	output logic                                       result_valid,
	output logic signed [cbl_pkg::SAMPLE_W-1:0]        filtered_sample
);

	localparam int AXW    = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
	localparam int DEPTH  = AXIS_COUNT * MAX_STAGES;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_W  = $bits(cbl_pkg::row_t);
	localparam logic [cbl_pkg::ALPHA_W:0] ALPHA_ONE = (cbl_pkg::ALPHA_W+1)'(65536);

	logic [AXW-1:0]                          axis_q;
	logic signed [cbl_pkg::STATE_W-1:0]      v_q;
	logic signed [cbl_pkg::ACC_W-1:0]        acc_q;
	logic signed [cbl_pkg::TAP_SUM_W-1:0]    tap_sum_q;
	logic [ADDR_W-1:0]                       addr_q;
	logic                                    hit_q;
	logic signed [cbl_pkg::STATE_W-1:0]      smem_q [AXIS_COUNT];
	logic [DEPTH-1:0]                        row_valid_q;
	logic                                    result_valid_q;
	logic signed [cbl_pkg::SAMPLE_W-1:0]     result_q;

	logic [ADDR_W-1:0]                       base_addr;
	logic [ADDR_W-1:0]                       raddr;
	logic [ROW_W-1:0]                        rd_bits;
	cbl_pkg::row_t                           row;
	cbl_pkg::row_t                           wr_row;
	cbl_pkg::coef_reg_t                      coef_sel;
	logic signed [cbl_pkg::COEF_W-1:0]       b0, a1, a2;
	logic signed [cbl_pkg::TAP_SUM_W-1:0]    mul_a;
	logic signed [cbl_pkg::COEF_W-1:0]       mul_b;
	logic signed [cbl_pkg::PROD_W-1:0]       prod;
	logic signed [cbl_pkg::STATE_W-1:0]      y_round;
	logic signed [cbl_pkg::TAP_SUM_W-1:0]    tap_sum;
	logic                                    out_free;
	logic                                    we;

	assign base_addr = ADDR_W'(32'(axis_index) * MAX_STAGES);
	assign raddr     = (cmd.op == cbl_pkg::OP_LOAD) ? base_addr : addr_q + ADDR_W'(1);
	assign we        = (cmd.op == cbl_pkg::OP_ST_ROUND);

	// History of an entry that was never written since the last clear reads as zero.
	assign row = hit_q ? cbl_pkg::row_t'(rd_bits) : '0;

	assign coef_sel = stage_coefs[cmd.stage];
	assign b0 = signed'(coef_sel[cbl_pkg::COEF_W-1:0]);
	assign a1 = signed'(coef_sel[cbl_pkg::A1_LSB +: cbl_pkg::COEF_W]);
	assign a2 = signed'(coef_sel[cbl_pkg::A2_LSB +: cbl_pkg::COEF_W]);

	assign y_round = cbl_pkg::round_sat_state(acc_q);

	assign tap_sum = cbl_pkg::TAP_SUM_W'(v_q)
	               + cbl_pkg::TAP_SUM_W'(row.x1) + cbl_pkg::TAP_SUM_W'(row.x1)
	               + cbl_pkg::TAP_SUM_W'(row.x2);

	assign wr_row = '{x1: v_q, x2: row.x1, y1: y_round, y2: row.y1};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			cbl_pkg::OP_SM_MUL0: begin
				mul_a = cbl_pkg::TAP_SUM_W'(smem_q[axis_q]);
				mul_b = signed'(cbl_pkg::COEF_W'(alpha));
			end
			cbl_pkg::OP_SM_MUL1: begin
				mul_a = cbl_pkg::TAP_SUM_W'(v_q);
				mul_b = signed'(cbl_pkg::COEF_W'(ALPHA_ONE - (cbl_pkg::ALPHA_W+1)'(alpha)));
			end
			cbl_pkg::OP_ST_MUL0: begin
				mul_a = tap_sum_q;
				mul_b = b0;
			end
			cbl_pkg::OP_ST_MUL1: begin
				mul_a = cbl_pkg::TAP_SUM_W'(row.y1);
				mul_b = a1;
			end
			cbl_pkg::OP_ST_MUL2: begin
				mul_a = cbl_pkg::TAP_SUM_W'(row.y2);
				mul_b = a2;
			end
			default: begin
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	assign out_free      = !result_valid_q || !result_stall;
	assign stat.out_free = out_free;

	cbl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(DEPTH)
	) u_history (
		.clk  (clk),
		.we   (we),
		.waddr(addr_q),
		.wdata(wr_row),
		.re   (cmd.rd),
		.raddr(raddr),
		.rdata(rd_bits)
	);

	// Working registers; none of them needs a reset value.
	always_ff @(posedge clk) begin
		case (cmd.op) inside
			cbl_pkg::OP_LOAD: begin
				axis_q <= AXW'(axis_index);
				v_q    <= {raw_sample, {cbl_pkg::STATE_FRAC{1'b0}}};
				addr_q <= base_addr;
			end
			cbl_pkg::OP_SM_MUL0, cbl_pkg::OP_ST_MUL0:
				acc_q <= cbl_pkg::ACC_W'(prod);
			cbl_pkg::OP_SM_MUL1, cbl_pkg::OP_ST_MUL1, cbl_pkg::OP_ST_MUL2:
				acc_q <= acc_q + cbl_pkg::ACC_W'(prod);
			cbl_pkg::OP_SM_ROUND:
				v_q <= y_round;
			cbl_pkg::OP_ST_SUM:
				tap_sum_q <= tap_sum;
			cbl_pkg::OP_ST_ROUND: begin
				v_q <= y_round;
				if (cmd.rd)
					addr_q <= addr_q + ADDR_W'(1);
			end
			default: begin
			end
		endcase
		if (cmd.rd)
			hit_q <= row_valid_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			for (int i = 0; i < AXIS_COUNT; i++)
				smem_q[i] <= '0;
		end else if (clear) begin
			row_valid_q <= '0;
			for (int i = 0; i < AXIS_COUNT; i++)
				smem_q[i] <= '0;
		end else begin
			if (we)
				row_valid_q[addr_q] <= 1'b1;
			if (cmd.op == cbl_pkg::OP_SM_ROUND)
				smem_q[axis_q] <= y_round;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.op == cbl_pkg::OP_OUT) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == cbl_pkg::OP_OUT)
			result_q <= cbl_pkg::round_sat_sample(v_q);
	end

	assign result_valid    = result_valid_q;
	assign filtered_sample = result_q;

endmodule

`default_nettype wire

@@ rtl/core/cbl_ctrl.sv @@
// ----------------------------------------------------------------------------
// Cascaded Butterworth low-pass: controller
// Sequences the smoother and the biquad stages of one item through the
// shared datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module cbl_ctrl #(
	parameter int AXIS_COUNT = 3,
	parameter int MAX_STAGES = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic [1:0]                    axis_index,
	input  wire logic [cbl_pkg::ORDER_W-1:0]   filter_order,
	input  wire cbl_pkg::stat_t                stat,
	output cbl_pkg::cmd_t                      cmd
);

	cbl_pkg::state_t state_q, state_d;
	logic [cbl_pkg::STAGE_CNT_W-1:0] stage_q, stage_d;

	logic [cbl_pkg::ORDER_W-1:0]     order_eff;
	logic [cbl_pkg::STAGE_CNT_W-1:0] half_order;
	logic [cbl_pkg::STAGE_CNT_W-1:0] stage_count;
	logic                            has_smoother;
	logic                            bypass;
	logic                            accept;
	logic                            last_stage;

	// Orders above eight behave as order eight.
	assign order_eff    = (filter_order > cbl_pkg::ORDER_LIMIT) ? cbl_pkg::ORDER_LIMIT
	                                                            : filter_order;
	assign half_order   = order_eff[cbl_pkg::ORDER_W-1:1];
	assign stage_count  = (32'(half_order) > MAX_STAGES)
	                      ? cbl_pkg::STAGE_CNT_W'(MAX_STAGES) : half_order;
	assign has_smoother = order_eff[0];
	assign bypass       = (filter_order == '0) || (32'(axis_index) >= AXIS_COUNT);
	assign accept       = sample_valid && (state_q == cbl_pkg::S_IDLE);
	assign last_stage   = (stage_q + cbl_pkg::STAGE_CNT_W'(1)) == stage_count;
	assign sample_stall = (state_q != cbl_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbl_pkg::S_IDLE;
			stage_q <= '0;
		end else begin
			state_q <= state_d;
			stage_q <= stage_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stage_d   = stage_q;
		cmd.op    = cbl_pkg::OP_NONE;
		cmd.stage = stage_q[cbl_pkg::STAGE_IDX_W-1:0];
		cmd.rd    = 1'b0;
		unique case (state_q)
			cbl_pkg::S_IDLE: begin
				if (accept) begin
					cmd.op  = cbl_pkg::OP_LOAD;
					cmd.rd  = !bypass;
					stage_d = '0;
					if (bypass)
						state_d = cbl_pkg::S_FINISH;
					else if (has_smoother)
						state_d = cbl_pkg::S_SM_MUL0;
					else if (stage_count != '0)
						state_d = cbl_pkg::S_ST_SUM;
					else
						state_d = cbl_pkg::S_FINISH;
				end
			end
			cbl_pkg::S_SM_MUL0: begin
				cmd.op  = cbl_pkg::OP_SM_MUL0;
				state_d = cbl_pkg::S_SM_MUL1;
			end
			cbl_pkg::S_SM_MUL1: begin
				cmd.op  = cbl_pkg::OP_SM_MUL1;
				state_d = cbl_pkg::S_SM_ROUND;
			end
			cbl_pkg::S_SM_ROUND: begin
				cmd.op  = cbl_pkg::OP_SM_ROUND;
				state_d = (stage_count != '0) ? cbl_pkg::S_ST_SUM : cbl_pkg::S_FINISH;
			end
			cbl_pkg::S_ST_SUM: begin
				cmd.op  = cbl_pkg::OP_ST_SUM;
				state_d = cbl_pkg::S_ST_MUL0;
			end
			cbl_pkg::S_ST_MUL0: begin
				cmd.op  = cbl_pkg::OP_ST_MUL0;
				state_d = cbl_pkg::S_ST_MUL1;
			end
			cbl_pkg::S_ST_MUL1: begin
				cmd.op  = cbl_pkg::OP_ST_MUL1;
				state_d = cbl_pkg::S_ST_MUL2;
			end
			cbl_pkg::S_ST_MUL2: begin
				cmd.op  = cbl_pkg::OP_ST_MUL2;
				state_d = cbl_pkg::S_ST_ROUND;
			end
			cbl_pkg::S_ST_ROUND: begin
				// The next stage's history is fetched while this one is written back.
				cmd.op = cbl_pkg::OP_ST_ROUND;
				if (last_stage) begin
					state_d = cbl_pkg::S_FINISH;
				end else begin
					cmd.rd  = 1'b1;
					stage_d = stage_q + cbl_pkg::STAGE_CNT_W'(1);
					state_d = cbl_pkg::S_ST_SUM;
				end
			end
			cbl_pkg::S_FINISH: begin
				if (stat.out_free) begin
					cmd.op  = cbl_pkg::OP_OUT;
					state_d = cbl_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cbl_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ test/cascaded_butterworth_lowpass_test.sv @@
// ----------------------------------------------------------------------------
// Testbench for the cascaded Butterworth low-pass filter
// Drives tagged samples through the sample channel and programs the order,
// smoothing factor and biquad coefficients between phases. A predictor with
// its own copy of the per-axis history works out each filtered sample, and a
// monitor compares every result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cascaded_butterworth_lowpass_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AXES          = 3;
	localparam int STAGES        = 4;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int LONG_HOLD     = 300;
	localparam int DRAIN_SETTLE  = 4;
	localparam int END_SETTLE    = 40;
	localparam int REPORT_LIMIT  = 10;

	// Indexes past the register list; writes to them are dropped.
	localparam logic [cbl_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [cbl_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum {COEF_STABLE, COEF_WILD, COEF_EDGE, COEF_MIXED} coef_style_t;

	typedef struct {
		logic [1:0]                          axis;
		logic signed [cbl_pkg::SAMPLE_W-1:0] raw;
	} sample_item_t;

	typedef struct {
		logic [1:0]                          axis;
		logic signed [cbl_pkg::SAMPLE_W-1:0] raw;
		logic signed [cbl_pkg::SAMPLE_W-1:0] filtered;
	} filtered_item_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  sample_valid = 1'b0;
	logic                                  sample_stall;
	logic [1:0]                            axis_index = '0;
	logic signed [cbl_pkg::SAMPLE_W-1:0]   raw_sample = '0;
	logic                                  result_valid;
	logic                                  result_stall = 1'b0;
	logic signed [cbl_pkg::SAMPLE_W-1:0]   filtered_sample;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [cbl_pkg::REG_IDX_W-1:0]         cfg_index = '0;
	logic [cbl_pkg::CFG_DATA_W-1:0]        cfg_data = '0;

	cascaded_butterworth_lowpass #(
		.AXIS_COUNT(AXES),
		.MAX_STAGES(STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.axis_index(axis_index),
		.raw_sample(raw_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.filtered_sample(filtered_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor copy of the configuration and of the per-axis history.
	logic [cbl_pkg::ORDER_W-1:0]        cur_order;
	logic [cbl_pkg::ALPHA_W-1:0]        cur_alpha;
	cbl_pkg::coef_reg_t                 cur_coefs [STAGES];
	logic signed [cbl_pkg::STATE_W-1:0] smooth_mem [AXES];
	logic signed [cbl_pkg::STATE_W-1:0] x_d1 [AXES*STAGES];
	logic signed [cbl_pkg::STATE_W-1:0] x_d2 [AXES*STAGES];
	logic signed [cbl_pkg::STATE_W-1:0] y_d1 [AXES*STAGES];
	logic signed [cbl_pkg::STATE_W-1:0] y_d2 [AXES*STAGES];

	sample_item_t   pending_samples [$];
	filtered_item_t filtered_expect [$];
	sample_item_t   next_sample;
	filtered_item_t oldest_expect;
	int             queued_count = 0;
	int             accepted_count = 0;
	int             error_count = 0;
	int             holds_requested = 0;
	int             holds_served = 0;
	int             hold_left = 0;
	int             stall_left = 0;
	int             send_gap = 0;
	bit             steady = 1'b0;
	int             walk [AXES];

	function automatic void clear_history();
		foreach (smooth_mem[i]) smooth_mem[i] = '0;
		foreach (x_d1[i]) begin
			x_d1[i] = '0;
			x_d2[i] = '0;
			y_d1[i] = '0;
			y_d2[i] = '0;
		end
	endfunction

	function automatic void apply_register(logic [cbl_pkg::REG_IDX_W-1:0] idx,
		cbl_pkg::coef_reg_t data);
		case (idx) inside
			cbl_pkg::REG_FILTER_ORDER: begin
				cur_order = data[cbl_pkg::ORDER_W-1:0];
				clear_history();
			end
			cbl_pkg::REG_SMOOTHING_FACTOR: begin
				cur_alpha = data[cbl_pkg::ALPHA_W-1:0];
				clear_history();
			end
			cbl_pkg::REG_STAGE0_COEFS, cbl_pkg::REG_STAGE1_COEFS,
			cbl_pkg::REG_STAGE2_COEFS, cbl_pkg::REG_STAGE3_COEFS: begin
				cur_coefs[cbl_pkg::STAGE_IDX_W'(idx - cbl_pkg::REG_STAGE0_COEFS)] = data;
				clear_history();
			end
			default: ;
		endcase
	endfunction

	// Q.24 sum to Q.8 with round-half-up, saturated to the state width.
	function automatic logic signed [cbl_pkg::STATE_W-1:0] to_state(longint acc);
		longint s;
		s = (acc + 32768) >>> 16;
		if (s > 8388607)
			s = 8388607;
		else if (s < -8388608)
			s = -8388608;
		return s[cbl_pkg::STATE_W-1:0];
	endfunction

	function automatic longint coef_at(cbl_pkg::coef_reg_t packed_coefs, int lsb);
		logic signed [cbl_pkg::COEF_W-1:0] f;
		f = packed_coefs[lsb +: cbl_pkg::COEF_W];
		return f;
	endfunction

	function automatic logic signed [cbl_pkg::SAMPLE_W-1:0] lowpass_sample(
		logic [1:0] axis, logic signed [cbl_pkg::SAMPLE_W-1:0] raw);
		int unsigned                        ord;
		int unsigned                        nstages;
		int                                 idx;
		longint                             v;
		longint                             acc;
		longint                             alpha;
		longint                             b0;
		longint                             a1;
		longint                             a2;
		longint                             r;
		logic signed [cbl_pkg::STATE_W-1:0] y;
		if (cur_order == 0 || axis >= AXES)
			return raw;
		ord = (cur_order > 8) ? 8 : cur_order;
		v = longint'(raw) * 256;
		if (ord % 2 == 1) begin
			alpha = cur_alpha;
			acc = longint'(smooth_mem[axis]) * alpha + (65536 - alpha) * v;
			smooth_mem[axis] = to_state(acc);
			v = smooth_mem[axis];
		end
		nstages = ord / 2;
		if (nstages > STAGES)
			nstages = STAGES;
		for (int k = 0; k < nstages; k++) begin
			idx = axis * STAGES + k;
			b0 = coef_at(cur_coefs[k], 0);
			a1 = coef_at(cur_coefs[k], cbl_pkg::A1_LSB);
			a2 = coef_at(cur_coefs[k], cbl_pkg::A2_LSB);
			acc = b0 * (v + 2 * longint'(x_d1[idx]) + longint'(x_d2[idx]))
				+ a1 * longint'(y_d1[idx]) + a2 * longint'(y_d2[idx]);
			y = to_state(acc);
			y_d2[idx] = y_d1[idx];
			y_d1[idx] = y;
			x_d2[idx] = x_d1[idx];
			x_d1[idx] = v[cbl_pkg::STATE_W-1:0];
			v = y;
		end
		r = (v + 128) >>> 8;
		if (r > 32767)
			r = 32767;
		else if (r < -32768)
			r = -32768;
		return r[cbl_pkg::SAMPLE_W-1:0];
	endfunction

	// Mostly back-to-back, sometimes a short pause, now and then a long one.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Sample driver: a payload stays put while the block stalls it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				filtered_expect.push_back('{axis_index, raw_sample,
					lowpass_sample(axis_index, raw_sample)});
				accepted_count++;
			end
			if (!sample_valid || !sample_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					next_sample = pending_samples.pop_front();
					axis_index <= next_sample.axis;
					raw_sample <= next_sample.raw;
					sample_valid <= 1'b1;
					send_gap = steady ? 0 : draw_gap();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall, with an occasional long hold so the block backs up.
	always @(posedge clk) begin
		if (arst_n) begin
			if (holds_served != holds_requested) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				stall_left = steady ? 0 : draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (filtered_expect.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected result %0d with nothing outstanding",
						filtered_sample);
			end else begin
				oldest_expect = filtered_expect.pop_front();
				if (filtered_sample !== oldest_expect.filtered) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("mismatch: axis %0d raw %0d expected %0d got %0d",
							oldest_expect.axis, oldest_expect.raw,
							oldest_expect.filtered, filtered_sample);
				end
			end
		end
	end

	task automatic queue_sample(input logic [1:0] axis,
		input logic signed [cbl_pkg::SAMPLE_W-1:0] raw);
		pending_samples.push_back('{axis, raw});
		queued_count++;
	endtask

	task automatic wait_drained(input int settle);
		while (accepted_count != queued_count || filtered_expect.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_register(input logic [cbl_pkg::REG_IDX_W-1:0] idx,
		input cbl_pkg::coef_reg_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic cbl_pkg::coef_reg_t make_coefs(coef_style_t style);
		int a1;
		int a2;
		int b0;
		int lim;
		coef_style_t pick;
		pick = style;
		if (style == COEF_MIXED) begin
			a1 = $urandom_range(0, 99);
			pick = (a1 < 60) ? COEF_STABLE : (a1 < 85) ? COEF_WILD : COEF_EDGE;
		end
		case (pick)
			COEF_STABLE: begin
				// Poles inside the stability triangle, unity gain at DC.
				a2 = -int'($urandom_range(2000, 60000));
				lim = 65536 - a2 - 3000;
				a1 = int'($urandom_range(0, 2 * lim)) - lim;
				b0 = (65536 - a1 - a2) / 4;
				return {cbl_pkg::COEF_W'(a2), cbl_pkg::COEF_W'(a1), cbl_pkg::COEF_W'(b0)};
			end
			COEF_WILD:
				return cbl_pkg::CFG_DATA_W'({$urandom(), $urandom()});
			default:
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return {3{18'h1FFFF}};
					default: return {3{18'h20000}};
				endcase
		endcase
	endfunction

	// Upper data bits above a narrow register are filled with noise.
	task automatic program_filter(input logic [cbl_pkg::ORDER_W-1:0] order,
		input logic [cbl_pkg::ALPHA_W-1:0] alpha, input coef_style_t style);
		cbl_pkg::coef_reg_t noise;
		noise = cbl_pkg::CFG_DATA_W'({$urandom(), $urandom()});
		write_register(cbl_pkg::REG_STAGE0_COEFS, make_coefs(style));
		write_register(cbl_pkg::REG_STAGE1_COEFS, make_coefs(style));
		write_register(cbl_pkg::REG_SMOOTHING_FACTOR,
			{noise[cbl_pkg::CFG_DATA_W-1:cbl_pkg::ALPHA_W], alpha});
		write_register(cbl_pkg::REG_STAGE2_COEFS, make_coefs(style));
		write_register(cbl_pkg::REG_STAGE3_COEFS, make_coefs(style));
		write_register(cbl_pkg::REG_FILTER_ORDER,
			{noise[cbl_pkg::CFG_DATA_W-1:cbl_pkg::ORDER_W], order});
	endtask

	function automatic logic signed [cbl_pkg::SAMPLE_W-1:0] pick_raw(int axis);
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return cbl_pkg::SAMPLE_W'($urandom());
		if (r < 75) begin
			walk[axis] = walk[axis] + int'($urandom_range(0, 4000)) - 2000;
			if (walk[axis] > 32767)
				walk[axis] = 32767;
			else if (walk[axis] < -32768)
				walk[axis] = -32768;
			return cbl_pkg::SAMPLE_W'(walk[axis]);
		end
		if (r < 88)
			return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
		return cbl_pkg::SAMPLE_W'(int'($urandom_range(0, 510)) - 255);
	endfunction

	function automatic logic [cbl_pkg::ALPHA_W-1:0] pick_alpha();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			case ($urandom_range(0, 3))
				0: return '0;
				1: return 16'd1;
				2: return 16'h8000;
				default: return '1;
			endcase
		if (r < 60)
			return cbl_pkg::ALPHA_W'($urandom_range(50000, 65535));
		return cbl_pkg::ALPHA_W'($urandom());
	endfunction

	function automatic logic [cbl_pkg::ORDER_W-1:0] pick_order();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return cbl_pkg::ORDER_W'($urandom_range(9, 15));
		return cbl_pkg::ORDER_W'($urandom_range(1, 8));
	endfunction

	initial begin
		int phase;
		int random_sent;
		int n;
		int axis;
		cur_order = '0;
		cur_alpha = '0;
		foreach (cur_coefs[i]) cur_coefs[i] = '0;
		foreach (walk[i]) walk[i] = 0;
		clear_history();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the order is zero, so every sample passes straight through.
		queue_sample(2'd0, 16'sh8000);
		queue_sample(2'd1, 16'sh7FFF);
		queue_sample(2'd2, 16'sh0000);
		queue_sample(2'd3, -16'sd1);
		wait_drained(DRAIN_SETTLE);

		// Orders above eight behave as eight: four biquads and no smoother.
		program_filter(4'd9, '1, COEF_STABLE);
		repeat (3) queue_sample(2'd0, 16'sh7FFF);
		queue_sample(2'd1, 16'sh8000);
		queue_sample(2'd3, 16'sd12345);
		queue_sample(2'd2, 16'sd100);
		wait_drained(DRAIN_SETTLE);

		program_filter(4'd7, '0, COEF_STABLE);
		queue_sample(2'd0, 16'sh8000);
		queue_sample(2'd0, 16'sh7FFF);
		queue_sample(2'd1, 16'sd4000);
		wait_drained(DRAIN_SETTLE);

		// Writes past the register list must leave the history alone.
		write_register(REG_SPARE_LO, '1);
		write_register(REG_SPARE_HI, cbl_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
		queue_sample(2'd0, 16'sh7FFF);
		queue_sample(2'd1, 16'sd4000);
		wait_drained(DRAIN_SETTLE);

		program_filter(4'd1, '1, COEF_EDGE);
		queue_sample(2'd2, 16'sh7FFF);
		queue_sample(2'd2, 16'sh8000);
		wait_drained(DRAIN_SETTLE);
		program_filter(4'd2, 16'd1, COEF_WILD);
		queue_sample(2'd1, 16'sh7FFF);
		queue_sample(2'd1, 16'sh7FFF);
		wait_drained(DRAIN_SETTLE);

		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: program_filter(4'd8, '0, COEF_STABLE);
				1: program_filter(4'd15, '1, COEF_EDGE);
				2: program_filter(4'd5, 16'd60000, COEF_STABLE);
				3: program_filter(4'd0, pick_alpha(), COEF_WILD);
				default:
					if ($urandom_range(0, 4) == 0)
						write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
							cbl_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
					else if ($urandom_range(0, 5) == 0)
						write_register(cbl_pkg::REG_SMOOTHING_FACTOR,
							cbl_pkg::CFG_DATA_W'(pick_alpha()));
					else
						program_filter(pick_order(), pick_alpha(), COEF_MIXED);
			endcase
			steady = ($urandom_range(0, 3) == 0);
			n = $urandom_range(40, 140);
			for (int i = 0; i < n; i++) begin
				axis = ($urandom_range(0, 99) < 8) ? 3 : $urandom_range(0, AXES - 1);
				queue_sample(2'(axis), pick_raw(axis % AXES));
			end
			random_sent += n;
			// The receiver holds off while the sender keeps offering items.
			if (phase == 2 || phase == 9) begin
				steady = 1'b1;
				holds_requested++;
			end
			wait_drained(DRAIN_SETTLE);
			phase++;
		end

		steady = 1'b0;
		wait_drained(END_SETTLE);
		if (error_count == 0 && filtered_expect.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#15_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
